FILE: hdl/bcpe_pkg.sv
`timescale 1ns / 1ps
package bcpe_pkg;

    localparam int MAX_CTRL   = 64;
    localparam int MAX_KNOTS  = 128;
    localparam int MAX_DEGREE = 7;
    localparam int FRAC_BITS  = 16;

    localparam int KNOT_W  = FRAC_BITS + 1;
    localparam int COORD_W = 32;
    localparam int KADDR_W = $clog2(MAX_KNOTS);
    localparam int CADDR_W = $clog2(MAX_CTRL);
    localparam int DEG_W   = 3;
    localparam int LAST_W  = 6;
    localparam int SPAN_W  = 6;
    localparam int IDX_W   = 7;
    localparam int REQ_W   = 2;
    localparam int DIFF_W  = KNOT_W + 1;
    localparam int DEN_W   = DIFF_W + 1;
    localparam int PROD_W  = DIFF_W + KNOT_W + 1;
    localparam int CPROD_W = COORD_W + KNOT_W + 1;
    localparam int ACC_W   = 64;
    localparam int CNT_W   = 5;

    localparam logic [KNOT_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    localparam logic [REQ_W-1:0] REQ_KNOT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CTRL = 2'd1;
    localparam logic [REQ_W-1:0] REQ_EVAL = 2'd2;

    localparam logic CFG_DEGREE = 1'b0;
    localparam logic CFG_LAST   = 1'b1;

    localparam logic [2:0] KA_N1 = 3'd0;
    localparam logic [2:0] KA_I0 = 3'd1;
    localparam logic [2:0] KA_I1 = 3'd2;
    localparam logic [2:0] KA_I2 = 3'd3;
    localparam logic [2:0] KA_L  = 3'd4;
    localparam logic [2:0] KA_R  = 3'd5;

    typedef struct packed {
        logic       accept;
        logic       start;
        logic [2:0] k_sel;
        logic       ld_prev;
        logic       ld_span_n;
        logic       ld_span_p;
        logic       ld_span_i;
        logic       ld_left;
        logic       ld_right;
        logic       clr_saved;
        logic       ld_d;
        logic       mul_right;
        logic       mul_left;
        logic       div_start;
        logic       ld_qr;
        logic       ld_ql;
        logic       zero_q;
        logic       upd_base;
        logic       ld_base_j;
        logic       ld_prod;
        logic       add_acc;
        logic       ld_out;
        logic [6:0] i;
        logic [2:0] j;
        logic [2:0] r;
    } t_cmd;

    typedef struct packed {
        logic u_ge_k;
        logic span_hit;
        logic d_zero;
        logic div_done;
        logic ci_neg;
    } t_sts;

endpackage

FILE: hdl/bcpe_ram.sv
`timescale 1ns / 1ps
module bcpe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hdl/bcpe_div.sv
`timescale 1ns / 1ps
module bcpe_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [bcpe_pkg::PROD_W-1:0]  i_num,
    input  logic signed [bcpe_pkg::DEN_W-1:0]   i_den,
    output logic                                o_done,
    output logic [bcpe_pkg::KNOT_W-1:0]         o_quot
);
    localparam int QW = bcpe_pkg::KNOT_W;
    localparam int DW = bcpe_pkg::DEN_W;
    localparam int NW = bcpe_pkg::PROD_W;

    logic          r_busy, r_done;
    logic [bcpe_pkg::CNT_W-1:0] r_cnt;
    logic [DW-1:0] r_rem, r_dmag;
    logic [QW-1:0] r_lo, r_q;
    logic          r_neg, r_ovf;

    logic [NW-1:0] nmag;
    logic [DW-1:0] dmag;
    logic [DW:0]   rem2;

    assign nmag = i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
    assign dmag = i_den[DW-1] ? DW'(-i_den) : DW'(i_den);
    assign rem2 = {r_rem, r_lo[QW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == bcpe_pkg::CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= bcpe_pkg::CNT_W'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - bcpe_pkg::CNT_W'(1);
                if (r_cnt == bcpe_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg  <= i_num[NW-1] ^ i_den[DW-1];
            r_ovf  <= nmag >= {dmag, {QW{1'b0}}};
            r_rem  <= nmag[NW-1:QW];
            r_lo   <= nmag[QW-1:0];
            r_dmag <= dmag;
            r_q    <= '0;
        end else if (r_busy) begin
            r_lo <= {r_lo[QW-2:0], 1'b0};
            if (rem2 >= {1'b0, r_dmag}) begin
                r_rem <= DW'(rem2 - {1'b0, r_dmag});
                r_q   <= {r_q[QW-2:0], 1'b1};
            end else begin
                r_rem <= rem2[DW-1:0];
                r_q   <= {r_q[QW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? '0 : (r_ovf || r_q > bcpe_pkg::ONE) ? bcpe_pkg::ONE : r_q;
endmodule

FILE: hdl/bcpe_dp.sv
`timescale 1ns / 1ps
module bcpe_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  bcpe_pkg::t_cmd                       i_cmd,
    output bcpe_pkg::t_sts                       o_sts,
    input  logic [bcpe_pkg::DEG_W-1:0]           i_degree,
    input  logic [bcpe_pkg::LAST_W-1:0]          i_last,
    input  logic [bcpe_pkg::REQ_W-1:0]           i_req_type,
    input  logic [bcpe_pkg::IDX_W-1:0]           i_table_index,
    input  logic [bcpe_pkg::KNOT_W-1:0]          i_knot_value,
    input  logic signed [bcpe_pkg::COORD_W-1:0]  i_coord_x,
    input  logic signed [bcpe_pkg::COORD_W-1:0]  i_coord_y,
    input  logic signed [bcpe_pkg::COORD_W-1:0]  i_coord_z,
    input  logic [bcpe_pkg::KNOT_W-1:0]          i_param_u,
    output logic signed [bcpe_pkg::COORD_W-1:0]  o_point_x,
    output logic signed [bcpe_pkg::COORD_W-1:0]  o_point_y,
    output logic signed [bcpe_pkg::COORD_W-1:0]  o_point_z,
    output logic [bcpe_pkg::SPAN_W-1:0]          o_span_index,
    output logic                                 o_degenerate_flag
);
    localparam int KW = bcpe_pkg::KNOT_W;
    localparam int CW = bcpe_pkg::COORD_W;
    localparam int AW = bcpe_pkg::ACC_W;
    localparam logic signed [AW-1:0] ACC_LIM = 64'sd1 <<< 62;
    localparam logic signed [AW-1:0] Q_MAX   = 64'sd2147483647;
    localparam logic signed [AW-1:0] Q_MIN   = -64'sd2147483648;

    logic [KW-1:0]                     r_u, r_prev;
    logic [bcpe_pkg::SPAN_W-1:0]       r_span;
    logic                              r_lneg, r_degen;
    logic signed [bcpe_pkg::DIFF_W-1:0] r_left  [0:bcpe_pkg::MAX_DEGREE];
    logic signed [bcpe_pkg::DIFF_W-1:0] r_right [0:bcpe_pkg::MAX_DEGREE];
    logic [KW-1:0]                     r_base  [0:bcpe_pkg::MAX_DEGREE];
    logic [KW-1:0]                     r_saved, r_qr, r_ql;
    logic signed [bcpe_pkg::DEN_W-1:0]  r_d;
    logic signed [bcpe_pkg::PROD_W-1:0] r_mul;
    logic signed [bcpe_pkg::CPROD_W-1:0] r_prod [0:2];
    logic signed [AW-1:0]              r_acc  [0:2];
    logic signed [CW-1:0]              r_pt   [0:2];
    logic [bcpe_pkg::SPAN_W-1:0]       r_span_out;
    logic                              r_degen_out;

    logic [bcpe_pkg::KADDR_W-1:0] k_raddr;
    logic [KW-1:0]                k_rdata;
    logic [3*CW-1:0]              c_rdata;
    logic [7:0]                   lidx, ci;
    logic                         k_we, c_we;
    logic [KW-1:0]                div_q;
    logic                         div_done;
    logic [KW:0]                  bsum;
    logic signed [CW-1:0]         coord [0:2];
    logic signed [AW-1:0]         asum  [0:2];
    logic signed [AW-1:0]         qfin  [0:2];

    assign lidx = {2'b0, r_span} + 8'd1 - {5'b0, i_cmd.j};
    assign ci   = {2'b0, r_span} - {5'b0, i_degree} + {5'b0, i_cmd.r};

    always_comb begin
        unique case (i_cmd.k_sel)
            bcpe_pkg::KA_N1: k_raddr = {1'b0, i_last} + 7'd1;
            bcpe_pkg::KA_I0: k_raddr = i_cmd.i;
            bcpe_pkg::KA_I1: k_raddr = i_cmd.i + 7'd1;
            bcpe_pkg::KA_I2: k_raddr = i_cmd.i + 7'd2;
            bcpe_pkg::KA_L:  k_raddr = lidx[6:0];
            bcpe_pkg::KA_R:  k_raddr = {1'b0, r_span} + {4'b0, i_cmd.j};
            default:         k_raddr = '0;
        endcase
    end

    assign k_we = i_cmd.accept && i_req_type == bcpe_pkg::REQ_KNOT;
    assign c_we = i_cmd.accept && i_req_type == bcpe_pkg::REQ_CTRL && !i_table_index[6];

    bcpe_ram #(.WIDTH(KW), .DEPTH(bcpe_pkg::MAX_KNOTS)) u_knot_ram (
        .i_clk   (i_clk),
        .i_we    (k_we),
        .i_waddr (i_table_index),
        .i_wdata (i_knot_value),
        .i_raddr (k_raddr),
        .o_rdata (k_rdata)
    );

    bcpe_ram #(.WIDTH(3 * CW), .DEPTH(bcpe_pkg::MAX_CTRL)) u_ctrl_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (i_table_index[5:0]),
        .i_wdata ({i_coord_z, i_coord_y, i_coord_x}),
        .i_raddr (ci[5:0]),
        .o_rdata (c_rdata)
    );

    bcpe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_mul),
        .i_den   (r_d),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    assign coord[0] = c_rdata[CW-1:0];
    assign coord[1] = c_rdata[2*CW-1:CW];
    assign coord[2] = c_rdata[3*CW-1:2*CW];
    assign bsum     = {1'b0, r_saved} + {1'b0, r_qr};

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            asum[k] = r_acc[k] + AW'(r_prod[k]);
            if (asum[k] > ACC_LIM) asum[k] = ACC_LIM;
            if (asum[k] < -ACC_LIM) asum[k] = -ACC_LIM;
            qfin[k] = r_acc[k] >>> bcpe_pkg::FRAC_BITS;
            if (qfin[k] > Q_MAX) qfin[k] = Q_MAX;
            if (qfin[k] < Q_MIN) qfin[k] = Q_MIN;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lneg <= lidx[7];
        if (i_cmd.start) begin
            r_u       <= i_param_u;
            r_base[0] <= bcpe_pkg::ONE;
            for (int k = 0; k < 3; k++) r_acc[k] <= '0;
        end
        if (i_cmd.ld_prev)   r_prev <= k_rdata;
        if (i_cmd.ld_span_n) r_span <= i_last;
        if (i_cmd.ld_span_p) r_span <= {3'b0, i_degree};
        if (i_cmd.ld_span_i) r_span <= i_cmd.i[5:0];
        if (i_cmd.ld_left) begin
            r_left[i_cmd.j] <= $signed({1'b0, r_u}) -
                               $signed({1'b0, r_lneg ? {KW{1'b0}} : k_rdata});
        end
        if (i_cmd.ld_right) r_right[i_cmd.j] <= $signed({1'b0, k_rdata}) - $signed({1'b0, r_u});
        if (i_cmd.clr_saved) r_saved <= '0;
        if (i_cmd.ld_d) begin
            r_d <= bcpe_pkg::DEN_W'(r_right[i_cmd.r + 3'd1]) +
                   bcpe_pkg::DEN_W'(r_left[i_cmd.j - i_cmd.r]);
        end
        if (i_cmd.mul_right) r_mul <= r_right[i_cmd.r + 3'd1] * $signed({1'b0, r_base[i_cmd.r]});
        if (i_cmd.mul_left)  r_mul <= r_left[i_cmd.j - i_cmd.r] * $signed({1'b0, r_base[i_cmd.r]});
        if (i_cmd.ld_qr) r_qr <= div_q;
        if (i_cmd.ld_ql) r_ql <= div_q;
        if (i_cmd.zero_q) begin
            r_qr <= '0;
            r_ql <= '0;
        end
        if (i_cmd.upd_base) begin
            r_base[i_cmd.r] <= (bsum > {1'b0, bcpe_pkg::ONE}) ? bcpe_pkg::ONE : bsum[KW-1:0];
            r_saved         <= r_ql;
        end
        if (i_cmd.ld_base_j) r_base[i_cmd.j] <= r_ql;
        if (i_cmd.ld_prod) begin
            for (int k = 0; k < 3; k++) begin
                r_prod[k] <= coord[k] * $signed({1'b0, r_base[i_cmd.r]});
            end
        end
        if (i_cmd.add_acc) begin
            for (int k = 0; k < 3; k++) r_acc[k] <= asum[k];
        end
        if (i_cmd.ld_out) begin
            for (int k = 0; k < 3; k++) r_pt[k] <= qfin[k][CW-1:0];
            r_span_out  <= r_span;
            r_degen_out <= r_degen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degen <= 1'b0;
        end else if (i_cmd.start) begin
            r_degen <= 1'b0;
        end else if (i_cmd.zero_q) begin
            r_degen <= 1'b1;
        end
    end

    assign o_sts.u_ge_k   = r_u >= k_rdata;
    assign o_sts.span_hit = (r_prev <= r_u) && (r_u < k_rdata);
    assign o_sts.d_zero   = r_d == '0;
    assign o_sts.div_done = div_done;
    assign o_sts.ci_neg   = ci[7];

    assign o_point_x         = r_pt[0];
    assign o_point_y         = r_pt[1];
    assign o_point_z         = r_pt[2];
    assign o_span_index      = r_span_out;
    assign o_degenerate_flag = r_degen_out;
endmodule

FILE: hdl/bcpe_ctrl.sv
`timescale 1ns / 1ps
module bcpe_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [bcpe_pkg::REQ_W-1:0]   i_req_type,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    input  logic [bcpe_pkg::DEG_W-1:0]   i_degree,
    input  logic [bcpe_pkg::LAST_W-1:0]  i_last,
    input  bcpe_pkg::t_sts               i_sts,
    output bcpe_pkg::t_cmd               o_cmd
);
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_KN   = 5'd1;
    localparam logic [4:0] S_KNC  = 5'd2;
    localparam logic [4:0] S_SPA  = 5'd3;
    localparam logic [4:0] S_SPB  = 5'd4;
    localparam logic [4:0] S_SPC  = 5'd5;
    localparam logic [4:0] S_L    = 5'd6;
    localparam logic [4:0] S_LW   = 5'd7;
    localparam logic [4:0] S_RW   = 5'd8;
    localparam logic [4:0] S_D    = 5'd9;
    localparam logic [4:0] S_MR   = 5'd10;
    localparam logic [4:0] S_DR0  = 5'd11;
    localparam logic [4:0] S_DVR  = 5'd12;
    localparam logic [4:0] S_DL0  = 5'd13;
    localparam logic [4:0] S_DVL  = 5'd14;
    localparam logic [4:0] S_UPD  = 5'd15;
    localparam logic [4:0] S_CR   = 5'd16;
    localparam logic [4:0] S_CW   = 5'd17;
    localparam logic [4:0] S_CA   = 5'd18;
    localparam logic [4:0] S_FIN  = 5'd19;

    logic [4:0] r_state, n_state;
    logic [6:0] r_i, n_i;
    logic [2:0] r_j, n_j, r_r, n_r;
    logic       r_out_valid, n_out_valid;
    logic [4:0] after_span;

    assign after_span = (i_degree == '0) ? S_CR : S_L;
    assign o_in_ready = r_state == S_IDLE;

    always_comb begin
        o_cmd       = '0;
        o_cmd.i     = r_i;
        o_cmd.j     = r_j;
        o_cmd.r     = r_r;
        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_r         = r_r;
        n_out_valid = i_out_ready ? 1'b0 : r_out_valid;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid && i_req_type == bcpe_pkg::REQ_EVAL) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_KN;
                end
            end
            S_KN: begin
                o_cmd.k_sel = bcpe_pkg::KA_N1;
                n_state     = S_KNC;
            end
            S_KNC: begin
                n_j = 3'd1;
                n_r = 3'd0;
                if (i_sts.u_ge_k) begin
                    o_cmd.ld_span_n = 1'b1;
                    n_state         = after_span;
                end else if ({3'b0, i_degree} > i_last) begin
                    o_cmd.ld_span_p = 1'b1;
                    n_state         = after_span;
                end else begin
                    n_i     = {4'b0, i_degree};
                    n_state = S_SPA;
                end
            end
            S_SPA: begin
                o_cmd.k_sel = bcpe_pkg::KA_I0;
                n_state     = S_SPB;
            end
            S_SPB: begin
                o_cmd.ld_prev = 1'b1;
                o_cmd.k_sel   = bcpe_pkg::KA_I1;
                n_state       = S_SPC;
            end
            S_SPC: begin
                o_cmd.k_sel = bcpe_pkg::KA_I2;
                if (i_sts.span_hit) begin
                    o_cmd.ld_span_i = 1'b1;
                    n_state         = after_span;
                end else if (r_i == {1'b0, i_last}) begin
                    o_cmd.ld_span_p = 1'b1;
                    n_state         = after_span;
                end else begin
                    o_cmd.ld_prev = 1'b1;
                    n_i           = r_i + 7'd1;
                end
            end
            S_L: begin
                o_cmd.k_sel = bcpe_pkg::KA_L;
                n_state     = S_LW;
            end
            S_LW: begin
                o_cmd.ld_left = 1'b1;
                o_cmd.k_sel   = bcpe_pkg::KA_R;
                n_state       = S_RW;
            end
            S_RW: begin
                o_cmd.ld_right  = 1'b1;
                o_cmd.clr_saved = 1'b1;
                n_r             = 3'd0;
                n_state         = S_D;
            end
            S_D: begin
                o_cmd.ld_d = 1'b1;
                n_state    = S_MR;
            end
            S_MR: begin
                if (i_sts.d_zero) begin
                    o_cmd.zero_q = 1'b1;
                    n_state      = S_UPD;
                end else begin
                    o_cmd.mul_right = 1'b1;
                    n_state         = S_DR0;
                end
            end
            S_DR0: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DVR;
            end
            S_DVR: begin
                if (i_sts.div_done) begin
                    o_cmd.ld_qr    = 1'b1;
                    o_cmd.mul_left = 1'b1;
                    n_state        = S_DL0;
                end
            end
            S_DL0: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DVL;
            end
            S_DVL: begin
                if (i_sts.div_done) begin
                    o_cmd.ld_ql = 1'b1;
                    n_state     = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.upd_base = 1'b1;
                if (r_r == r_j - 3'd1) begin
                    o_cmd.ld_base_j = 1'b1;
                    if (r_j == i_degree) begin
                        n_r     = 3'd0;
                        n_state = S_CR;
                    end else begin
                        n_j     = r_j + 3'd1;
                        n_state = S_L;
                    end
                end else begin
                    n_r     = r_r + 3'd1;
                    n_state = S_D;
                end
            end
            S_CR: begin
                if (!i_sts.ci_neg) begin
                    n_state = S_CW;
                end else if (r_r == i_degree) begin
                    n_state = S_FIN;
                end else begin
                    n_r = r_r + 3'd1;
                end
            end
            S_CW: begin
                o_cmd.ld_prod = 1'b1;
                n_state       = S_CA;
            end
            S_CA: begin
                o_cmd.add_acc = 1'b1;
                if (r_r == i_degree) begin
                    n_state = S_FIN;
                end else begin
                    n_r     = r_r + 3'd1;
                    n_state = S_CR;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.ld_out = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_r         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_i         <= n_i;
            r_j         <= n_j;
            r_r         <= n_r;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
endmodule

FILE: hdl/bspline_curve_point_eval_core.sv
`timescale 1ns / 1ps
// B-spline curve point evaluator. Knot and control point write requests
// are written as they are accepted. An evaluate request runs the span
// search (one knot read a cycle), then the Cox-de Boor recurrence, where
// each of the p(p+1)/2 terms makes two passes through the shared 17-step
// restoring divider unless its denominator is zero, with knot reads at
// each degree level, then the weighted sum over the control points.
// One request is worked on at a time; a finished point waits in the output
// register while the next request is taken. Config writes are always ready.
module bspline_curve_point_eval_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic                                 i_cfg_index,
    input  logic [bcpe_pkg::LAST_W-1:0]          i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [bcpe_pkg::REQ_W-1:0]           i_req_type,
    input  logic [bcpe_pkg::IDX_W-1:0]           i_table_index,
    input  logic [bcpe_pkg::KNOT_W-1:0]          i_knot_value,
    input  logic signed [bcpe_pkg::COORD_W-1:0]  i_coord_x,
    input  logic signed [bcpe_pkg::COORD_W-1:0]  i_coord_y,
    input  logic signed [bcpe_pkg::COORD_W-1:0]  i_coord_z,
    input  logic [bcpe_pkg::KNOT_W-1:0]          i_param_u,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [bcpe_pkg::COORD_W-1:0]  o_point_x,
    output logic signed [bcpe_pkg::COORD_W-1:0]  o_point_y,
    output logic signed [bcpe_pkg::COORD_W-1:0]  o_point_z,
    output logic [bcpe_pkg::SPAN_W-1:0]          o_span_index,
    output logic                                 o_degenerate_flag
);
    logic [bcpe_pkg::DEG_W-1:0]  r_degree;
    logic [bcpe_pkg::LAST_W-1:0] r_last;
    bcpe_pkg::t_cmd cmd;
    bcpe_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= 3'd3;
            r_last   <= 6'd3;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bcpe_pkg::CFG_DEGREE: r_degree <= i_cfg_data[bcpe_pkg::DEG_W-1:0];
                bcpe_pkg::CFG_LAST:   r_last   <= i_cfg_data;
                default:              r_last   <= r_last;
            endcase
        end
    end

    bcpe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_degree    (r_degree),
        .i_last      (r_last),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bcpe_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_degree          (r_degree),
        .i_last            (r_last),
        .i_req_type        (i_req_type),
        .i_table_index     (i_table_index),
        .i_knot_value      (i_knot_value),
        .i_coord_x         (i_coord_x),
        .i_coord_y         (i_coord_y),
        .i_coord_z         (i_coord_z),
        .i_param_u         (i_param_u),
        .o_point_x         (o_point_x),
        .o_point_y         (o_point_y),
        .o_point_z         (o_point_z),
        .o_span_index      (o_span_index),
        .o_degenerate_flag (o_degenerate_flag)
    );
endmodule

FILE: verif/bcpe_checker.sv
`timescale 1ns / 1ps
module bcpe_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    input  logic                                 i_cfg_ready,
    input  logic                                 i_cfg_index,
    input  logic [bcpe_pkg::LAST_W-1:0]          i_cfg_data,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_ready,
    input  logic [bcpe_pkg::REQ_W-1:0]           i_req_type,
    input  logic [bcpe_pkg::IDX_W-1:0]           i_table_index,
    input  logic [bcpe_pkg::KNOT_W-1:0]          i_knot_value,
    input  logic signed [bcpe_pkg::COORD_W-1:0]  i_coord_x,
    input  logic signed [bcpe_pkg::COORD_W-1:0]  i_coord_y,
    input  logic signed [bcpe_pkg::COORD_W-1:0]  i_coord_z,
    input  logic [bcpe_pkg::KNOT_W-1:0]          i_param_u,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_ready,
    input  logic signed [bcpe_pkg::COORD_W-1:0]  i_point_x,
    input  logic signed [bcpe_pkg::COORD_W-1:0]  i_point_y,
    input  logic signed [bcpe_pkg::COORD_W-1:0]  i_point_z,
    input  logic [bcpe_pkg::SPAN_W-1:0]          i_span_index,
    input  logic                                 i_degenerate_flag,
    output int                                   o_pending,
    output int                                   o_fail_count
);
    typedef struct {
        logic signed [bcpe_pkg::COORD_W-1:0] x;
        logic signed [bcpe_pkg::COORD_W-1:0] y;
        logic signed [bcpe_pkg::COORD_W-1:0] z;
        logic [bcpe_pkg::SPAN_W-1:0]         span;
        logic                                degen;
    } t_point;

    localparam longint ONE_L = longint'(1) << bcpe_pkg::FRAC_BITS;
    localparam longint ACC_MAX = longint'(1) << 62;

    logic [bcpe_pkg::KNOT_W-1:0]         knot_tab [bcpe_pkg::MAX_KNOTS];
    logic signed [bcpe_pkg::COORD_W-1:0] ctrl_x [bcpe_pkg::MAX_CTRL];
    logic signed [bcpe_pkg::COORD_W-1:0] ctrl_y [bcpe_pkg::MAX_CTRL];
    logic signed [bcpe_pkg::COORD_W-1:0] ctrl_z [bcpe_pkg::MAX_CTRL];
    logic [bcpe_pkg::DEG_W-1:0]          cur_degree;
    logic [bcpe_pkg::LAST_W-1:0]         cur_last;
    t_point                              point_q [$];

    function automatic longint knot_at(input longint idx);
        if (idx < 0 || idx >= bcpe_pkg::MAX_KNOTS) return 0;
        return longint'(knot_tab[idx]);
    endfunction

    function automatic longint unit_clamp(input longint v);
        if (v < 0) return 0;
        if (v > ONE_L) return ONE_L;
        return v;
    endfunction

    function automatic logic signed [bcpe_pkg::COORD_W-1:0] to_coord(input longint acc);
        longint q;
        q = acc >>> bcpe_pkg::FRAC_BITS;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return q[bcpe_pkg::COORD_W-1:0];
    endfunction

    function automatic t_point curve_point(input logic [bcpe_pkg::KNOT_W-1:0] u_in);
        t_point res;
        longint p, n, u, span, d, qr, ql, saved, ci, a;
        longint base [bcpe_pkg::MAX_DEGREE+1];
        longint lft [bcpe_pkg::MAX_DEGREE+1];
        longint rgt [bcpe_pkg::MAX_DEGREE+1];
        longint acc [3];
        logic found;
        logic degen;
        p = (cur_degree > bcpe_pkg::MAX_DEGREE) ? bcpe_pkg::MAX_DEGREE : cur_degree;
        n = cur_last;
        u = u_in;
        degen = 1'b0;
        if (u >= knot_at(n + 1)) begin
            span = n;
        end else begin
            span = p;
            found = 1'b0;
            for (longint i = p; i <= n; i++) begin
                if (!found && knot_at(i) <= u && u < knot_at(i + 1)) begin
                    span = i;
                    found = 1'b1;
                end
            end
        end
        for (int k = 0; k <= bcpe_pkg::MAX_DEGREE; k++) begin
            base[k] = 0;
            lft[k] = 0;
            rgt[k] = 0;
        end
        base[0] = ONE_L;
        for (longint j = 1; j <= p; j++) begin
            saved = 0;
            lft[j] = u - knot_at(span + 1 - j);
            rgt[j] = knot_at(span + j) - u;
            for (longint r = 0; r < j; r++) begin
                d = rgt[r+1] + lft[j-r];
                qr = 0;
                ql = 0;
                if (d == 0) begin
                    degen = 1'b1;
                end else begin
                    qr = unit_clamp((rgt[r+1] * base[r]) / d);
                    ql = unit_clamp((lft[j-r] * base[r]) / d);
                end
                base[r] = unit_clamp(saved + qr);
                saved = ql;
            end
            base[j] = saved;
        end
        acc[0] = 0;
        acc[1] = 0;
        acc[2] = 0;
        for (longint r = 0; r <= p; r++) begin
            ci = span - p + r;
            if (ci >= 0 && ci < bcpe_pkg::MAX_CTRL) begin
                for (int k = 0; k < 3; k++) begin
                    a = acc[k] + base[r] * longint'(k == 0 ? ctrl_x[ci] :
                                                   k == 1 ? ctrl_y[ci] : ctrl_z[ci]);
                    if (a > ACC_MAX) a = ACC_MAX;
                    if (a < -ACC_MAX) a = -ACC_MAX;
                    acc[k] = a;
                end
            end
        end
        res.x = to_coord(acc[0]);
        res.y = to_coord(acc[1]);
        res.z = to_coord(acc[2]);
        res.span = span[bcpe_pkg::SPAN_W-1:0];
        res.degen = degen;
        return res;
    endfunction

    initial begin
        o_pending = 0;
        o_fail_count = 0;
        for (int k = 0; k < bcpe_pkg::MAX_KNOTS; k++) knot_tab[k] = '0;
        for (int k = 0; k < bcpe_pkg::MAX_CTRL; k++) begin
            ctrl_x[k] = '0;
            ctrl_y[k] = '0;
            ctrl_z[k] = '0;
        end
    end

    always @(posedge i_clk) begin
        t_point want;
        if (!i_rst_n) begin
            cur_degree <= 3'd3;
            cur_last <= 6'd3;
            point_q.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == bcpe_pkg::CFG_DEGREE) begin
                    cur_degree <= i_cfg_data[bcpe_pkg::DEG_W-1:0];
                end else begin
                    cur_last <= i_cfg_data;
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (point_q.size() == 0) begin
                    $display("%0t: unexpected point x %0d y %0d z %0d span %0d flag %0b",
                             $time, i_point_x, i_point_y, i_point_z, i_span_index,
                             i_degenerate_flag);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = point_q.pop_front();
                    if (want.x !== i_point_x || want.y !== i_point_y ||
                        want.z !== i_point_z || want.span !== i_span_index ||
                        want.degen !== i_degenerate_flag) begin
                        $display("%0t: expected x %0d y %0d z %0d span %0d flag %0b",
                                 $time, want.x, want.y, want.z, want.span, want.degen);
                        $display("%0t: actual   x %0d y %0d z %0d span %0d flag %0b",
                                 $time, i_point_x, i_point_y, i_point_z, i_span_index,
                                 i_degenerate_flag);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                case (i_req_type)
                    bcpe_pkg::REQ_KNOT: knot_tab[i_table_index] = i_knot_value;
                    bcpe_pkg::REQ_CTRL: begin
                        if (i_table_index < bcpe_pkg::MAX_CTRL) begin
                            ctrl_x[i_table_index[bcpe_pkg::CADDR_W-1:0]] = i_coord_x;
                            ctrl_y[i_table_index[bcpe_pkg::CADDR_W-1:0]] = i_coord_y;
                            ctrl_z[i_table_index[bcpe_pkg::CADDR_W-1:0]] = i_coord_z;
                        end
                    end
                    bcpe_pkg::REQ_EVAL: point_q.insert(point_q.size(), curve_point(i_param_u));
                    default: ;
                endcase
            end
            o_pending <= point_q.size();
        end
    end

endmodule

FILE: verif/tb_bspline_curve_point_eval_core.sv
`timescale 1ns / 1ps
module tb_bspline_curve_point_eval_core;

    localparam logic [bcpe_pkg::REQ_W-1:0] REQ_RSVD = 2'd3;
    localparam int ONE_I = 1 << bcpe_pkg::FRAC_BITS;
    localparam longint CYCLE_LIMIT = 8000000;

    logic                                  i_clk = 1'b0;
    logic                                  i_rst_n = 1'b0;
    logic                                  i_cfg_valid = 1'b0;
    logic                                  o_cfg_ready;
    logic                                  i_cfg_index = 1'b0;
    logic [bcpe_pkg::LAST_W-1:0]           i_cfg_data = '0;
    logic                                  i_in_valid = 1'b0;
    logic                                  o_in_ready;
    logic [bcpe_pkg::REQ_W-1:0]            i_req_type = '0;
    logic [bcpe_pkg::IDX_W-1:0]            i_table_index = '0;
    logic [bcpe_pkg::KNOT_W-1:0]           i_knot_value = '0;
    logic signed [bcpe_pkg::COORD_W-1:0]   i_coord_x = '0;
    logic signed [bcpe_pkg::COORD_W-1:0]   i_coord_y = '0;
    logic signed [bcpe_pkg::COORD_W-1:0]   i_coord_z = '0;
    logic [bcpe_pkg::KNOT_W-1:0]           i_param_u = '0;
    logic                                  o_out_valid;
    logic                                  i_out_ready = 1'b1;
    logic signed [bcpe_pkg::COORD_W-1:0]   o_point_x;
    logic signed [bcpe_pkg::COORD_W-1:0]   o_point_y;
    logic signed [bcpe_pkg::COORD_W-1:0]   o_point_z;
    logic [bcpe_pkg::SPAN_W-1:0]           o_span_index;
    logic                                  o_degenerate_flag;

    int     pending;
    int     fail_count;
    logic   quiet = 1'b0;
    int     stall_left = 0;
    longint cycle_count = 0;
    int     n_eval = 0;
    int     n_write = 0;
    int     n_settings = 0;

    always #4 i_clk = ~i_clk;

    bspline_curve_point_eval_core u_top (.*);

    bcpe_checker u_chk (
        .i_clk, .i_rst_n,
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .i_in_valid, .i_in_ready(o_in_ready), .i_req_type, .i_table_index,
        .i_knot_value, .i_coord_x, .i_coord_y, .i_coord_z, .i_param_u,
        .i_out_valid(o_out_valid), .i_out_ready,
        .i_point_x(o_point_x), .i_point_y(o_point_y), .i_point_z(o_point_z),
        .i_span_index(o_span_index), .i_degenerate_flag(o_degenerate_flag),
        .o_pending(pending), .o_fail_count(fail_count)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n || quiet) begin
            i_out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 9) == 0) begin
            i_out_ready <= 1'b0;
            stall_left <= $urandom_range(0, 6);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic put_req(input logic [bcpe_pkg::REQ_W-1:0] rt,
                           input logic [bcpe_pkg::IDX_W-1:0] idx,
                           input logic [bcpe_pkg::KNOT_W-1:0] kv,
                           input logic [bcpe_pkg::COORD_W-1:0] x,
                           input logic [bcpe_pkg::COORD_W-1:0] y,
                           input logic [bcpe_pkg::COORD_W-1:0] z,
                           input logic [bcpe_pkg::KNOT_W-1:0] u);
        logic rdy;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= rt;
        i_table_index <= idx;
        i_knot_value <= kv;
        i_coord_x <= x;
        i_coord_y <= y;
        i_coord_z <= z;
        i_param_u <= u;
        // ready is stable from the falling edge up to the next rising edge
        rdy = 1'b0;
        while (!rdy) begin
            @(negedge i_clk);
            rdy = o_in_ready;
            @(posedge i_clk);
        end
        if (rt == bcpe_pkg::REQ_EVAL) n_eval++;
        else n_write++;
    endtask

    task automatic knot_wr(input int idx, input int v);
        put_req(bcpe_pkg::REQ_KNOT, bcpe_pkg::IDX_W'(idx), bcpe_pkg::KNOT_W'(v),
                $urandom, $urandom, $urandom, bcpe_pkg::KNOT_W'($urandom));
    endtask

    task automatic ctrl_wr(input int idx, input logic [31:0] x, input logic [31:0] y,
                           input logic [31:0] z);
        put_req(bcpe_pkg::REQ_CTRL, bcpe_pkg::IDX_W'(idx), bcpe_pkg::KNOT_W'($urandom),
                x, y, z, bcpe_pkg::KNOT_W'($urandom));
    endtask

    task automatic eval_at(input int u);
        put_req(bcpe_pkg::REQ_EVAL, bcpe_pkg::IDX_W'($urandom),
                bcpe_pkg::KNOT_W'($urandom), $urandom, $urandom, $urandom,
                bcpe_pkg::KNOT_W'(u));
    endtask

    task automatic rsvd_req();
        put_req(REQ_RSVD, bcpe_pkg::IDX_W'($urandom), bcpe_pkg::KNOT_W'($urandom),
                $urandom, $urandom, $urandom, bcpe_pkg::KNOT_W'($urandom));
    endtask

    task automatic wait_idle(input int tail);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    task automatic cfg_wr(input logic index, input int data);
        logic rdy;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= bcpe_pkg::LAST_W'(data);
        rdy = 1'b0;
        while (!rdy) begin
            @(negedge i_clk);
            rdy = o_cfg_ready;
            @(posedge i_clk);
        end
    endtask

    task automatic set_cfg(input int deg, input int last);
        cfg_wr(bcpe_pkg::CFG_DEGREE, deg);
        cfg_wr(bcpe_pkg::CFG_LAST, last);
        i_cfg_valid <= 1'b0;
        n_settings++;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2, 3: return $urandom;
            default: return $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000;
        endcase
    endfunction

    // clamped knot vector with random sorted interior, then fresh points
    task automatic load_curve(input int p, input int n);
        int inner [$];
        for (int k = p + 1; k <= n; k++) begin
            if ($urandom_range(0, 3) == 0) begin
                inner.insert(inner.size(), $urandom_range(0, 16) * 4096);
            end else begin
                inner.insert(inner.size(), $urandom_range(0, ONE_I));
            end
        end
        inner.sort();
        for (int k = 0; k <= n + p + 1; k++) begin
            if (k <= p) knot_wr(k, 0);
            else if (k <= n) knot_wr(k, inner[k-p-1]);
            else knot_wr(k, ONE_I);
        end
        for (int k = 0; k <= n; k++) ctrl_wr(k, rand_coord(), rand_coord(), rand_coord());
    endtask

    task automatic random_mix(input int count);
        int sel;
        for (int k = 0; k < count; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 55) eval_at($urandom_range(0, ONE_I));
            else if (sel < 65) eval_at($urandom_range(0, 16) * 4096);
            else if (sel < 75) eval_at($urandom_range(0, 131071));
            else if (sel < 85) knot_wr($urandom_range(0, 127), $urandom_range(0, 131071));
            else if (sel < 95) ctrl_wr($urandom_range(0, 127), $urandom, $urandom, $urandom);
            else rsvd_req();
        end
    endtask

    initial begin
        int degs [6];
        int lasts [6];
        degs = '{1, 7, 2, 7, 5, 0};
        lasts = '{1, 63, 10, 7, 40, 0};
        degs[5] = $urandom_range(1, 7);
        lasts[5] = $urandom_range(1, 63);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill both tables so nothing unwritten is ever read
        for (int k = 0; k < bcpe_pkg::MAX_KNOTS; k++) knot_wr(k, (k <= 3) ? 0 : ONE_I);
        for (int k = 0; k < bcpe_pkg::MAX_CTRL; k++) begin
            ctrl_wr(k, rand_coord(), rand_coord(), rand_coord());
        end

        // directed, reset settings p=3 n=3
        eval_at(0);
        eval_at(ONE_I);
        eval_at(131071);
        eval_at(32768);
        ctrl_wr(0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        ctrl_wr(1, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
        ctrl_wr(2, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001);
        ctrl_wr(3, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
        eval_at(21845);
        ctrl_wr(100, 32'h1234_5678, 32'h1234_5678, 32'h1234_5678);
        ctrl_wr(127, 32'hdead_beef, 32'hdead_beef, 32'hdead_beef);
        put_req(REQ_RSVD, 7'd127, 17'd131071, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                17'd131071);
        knot_wr(3, 16384);
        eval_at(4096);
        knot_wr(5, 0);
        eval_at(36864);
        knot_wr(127, 131071);
        knot_wr(3, 0);
        knot_wr(5, ONE_I);
        eval_at(65535);
        eval_at(1);

        wait_idle(20);

        for (int ph = 0; ph < 6; ph++) begin
            set_cfg(degs[ph], lasts[ph]);
            load_curve(degs[ph], lasts[ph]);
            if (ph == 5) quiet = 1'b1;
            random_mix(60);
            wait_idle(20);
        end

        wait_idle(1500);
        $display("Covered %0d evaluations and %0d writes or ignored requests", n_eval, n_write);
        $display("over %0d degree and control count settings, degree 1 to 7, n 1 to 63",
                 n_settings + 1);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/bcpe_pkg.sv
hdl/bcpe_ram.sv
hdl/bcpe_div.sv
hdl/bcpe_dp.sv
hdl/bcpe_ctrl.sv
hdl/bspline_curve_point_eval_core.sv
verif/bcpe_checker.sv
verif/tb_bspline_curve_point_eval_core.sv
